@@ hdl/piecewise_trajectory_table_evaluator_defines.svh @@
// Assertion macros shared by the evaluator modules.
`ifndef PIECEWISE_TRAJECTORY_TABLE_EVALUATOR_DEFINES_SVH
`define PIECEWISE_TRAJECTORY_TABLE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTTE_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTTE_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ptte_pkg.sv @@
package ptte_pkg;

	localparam logic [2:0] OP_CLEAR    = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_LINK_VEL = 3'd2;
	localparam logic [2:0] OP_LINK_ACC = 3'd3;
	localparam logic [2:0] OP_QUERY    = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ORDER    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_NOTEMPTY = 3'd4;

	localparam logic [3:0] JOINTS_RESET = 4'd6;

	typedef struct packed {
		logic [2:0]         op;
		logic [2:0]         joint;
		logic [31:0]        start_time;
		logic [31:0]        time_req;
		logic signed [31:0] pos_value;
		logic signed [31:0] vel_value;
		logic signed [31:0] acc_value;
		logic               last_joint;
	} item_t;

	typedef struct packed {
		logic [2:0]         out_joint;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
		logic               last;
		logic [2:0]         status;
	} result_t;

endpackage

@@ hdl/ptte_ram.sv @@
module ptte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/ptte_front.sv @@
`include "piecewise_trajectory_table_evaluator_defines.svh"
module ptte_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ptte_pkg::item_t item,
	output logic           busy,
	input  logic           pop,
	output ptte_pkg::item_t head,
	output logic           head_valid
);
	import ptte_pkg::*;

	item_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] fill_q;
	logic       push;

	assign busy       = (fill_q == 2'd2);
	// drop unknown ops at the door
	assign push       = start && !busy && (item.op <= OP_QUERY);
	assign head       = ent_q[rp_q];
	assign head_valid = (fill_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	`PTTE_AST_IMP(a_fill_range, 1'b1, fill_q <= 2'd2, "queue fill out of range")
	`PTTE_AST_IMP(a_pop_nonempty, pop, fill_q != 2'd0, "pop from empty queue")
	`PTTE_AST_NXT(a_fill_up, push && !pop, fill_q == $past(fill_q) + 2'd1, "fill not advanced")
endmodule

@@ hdl/ptte_back.sv @@
`include "piecewise_trajectory_table_evaluator_defines.svh"
module ptte_back #(
	parameter int MAX_SEGMENTS = 16,
	parameter int MAX_JOINTS   = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [$clog2(MAX_JOINTS+1)-1:0]  n,
	input  ptte_pkg::item_t                  head,
	input  logic                             head_valid,
	output logic                             pop,
	output ptte_pkg::result_t                result,
	output logic                             strobe
);
	import ptte_pkg::*;

	localparam int SW   = $clog2(MAX_SEGMENTS);
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int JW   = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int NW   = $clog2(MAX_JOINTS + 1);
	localparam int CMPW = (NW > 3) ? NW : 3;
	localparam int RD   = MAX_SEGMENTS * MAX_JOINTS;
	localparam int AW   = $clog2(RD);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DEC   = 4'd1;
	localparam logic [3:0] S_LK_TB = 4'd2;
	localparam logic [3:0] S_LK_C  = 4'd3;
	localparam logic [3:0] S_LK_N  = 4'd4;
	localparam logic [3:0] S_LK_S  = 4'd5;
	localparam logic [3:0] S_EA    = 4'd6;
	localparam logic [3:0] S_EDT   = 4'd7;
	localparam logic [3:0] S_M1    = 4'd8;
	localparam logic [3:0] S_M2    = 4'd9;
	localparam logic [3:0] S_M3    = 4'd10;
	localparam logic [3:0] S_M4    = 4'd11;
	localparam logic [3:0] S_M5    = 4'd12;
	localparam logic [3:0] S_M6    = 4'd13;
	localparam logic [3:0] S_SUM   = 4'd14;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
		logic signed [65:0] hi;
		logic signed [65:0] lo;
		hi = 66'sh0_7FFF_FFFF;
		lo = -66'sh0_8000_0000;
		if (x > hi) begin
			sat32 = 32'sh7FFF_FFFF;
		end else if (x < lo) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = x[31:0];
		end
	endfunction

	logic [3:0]         state_q;
	item_t              cur_q;
	logic [CW-1:0]      count_q;
	logic [SW-1:0]      cache_q;
	logic [SW-1:0]      i_q;
	logic [SW-1:0]      s_q;
	logic [NW-1:0]      j_q;
	logic [31:0]        t_q;
	logic signed [31:0] q0_q;
	logic signed [31:0] v0_q;
	logic signed [31:0] a0_q;
	logic [31:0]        ud_q;
	logic               dneg_q;
	logic [63:0]        prod_q;
	logic [31:0]        d2lo_q;
	logic [63:0]        hi_q;
	logic [63:0]        lo_q;
	logic [47:0]        lv_q;
	logic [47:0]        la_q;
	logic [62:0]        qd_q;
	result_t            res_q;
	logic               strobe_q;

	logic               tw_q;
	logic [SW-1:0]      twa_q;
	logic [63:0]        twd_q;
	logic               jw_q;
	logic [AW-1:0]      jwa_q;
	logic [95:0]        jwd_q;

	logic [SW-1:0]      t_raddr;
	logic [63:0]        trd;
	logic [AW-1:0]      j_raddr;
	logic [95:0]        jrd;
	logic [SW-1:0]      c_calc;
	logic               hit;
	logic               t_gt_e;
	logic               jok;
	logic               is_query;
	logic [JW-1:0]      jsel;
	logic [32:0]        dt;
	logic [31:0]        ua;
	logic [31:0]        uv;
	logic [31:0]        ma;
	logic [31:0]        mb;
	logic [63:0]        qtmp;
	logic signed [65:0] lin_v;
	logic signed [65:0] lin_a;
	logic signed [65:0] quad;
	logic signed [31:0] p_sat;
	logic signed [31:0] v_sat;
	logic               q_last;

	ptte_ram #(.WIDTH(64), .DEPTH(MAX_SEGMENTS)) u_time_ram (
		.clk   (clk),
		.we    (tw_q),
		.waddr (twa_q),
		.wdata (twd_q),
		.raddr (t_raddr),
		.rdata (trd)
	);

	ptte_ram #(.WIDTH(96), .DEPTH(RD)) u_coef_ram (
		.clk   (clk),
		.we    (jw_q),
		.waddr (jwa_q),
		.wdata (jwd_q),
		.raddr (j_raddr),
		.rdata (jrd)
	);

	assign pop      = (state_q == S_IDLE) && head_valid;
	assign result   = res_q;
	assign strobe   = strobe_q;
	assign c_calc   = (CW'(cache_q) >= count_q) ? '0 : cache_q;
	assign hit      = (t_q >= trd[63:32]) && (t_q <= trd[31:0]);
	assign t_gt_e   = (t_q > trd[31:0]);
	assign jok      = (CMPW'(cur_q.joint) < CMPW'(n));
	assign is_query = (cur_q.op == OP_QUERY);
	assign jsel     = is_query ? JW'(j_q) : JW'(cur_q.joint);
	assign j_raddr  = AW'(s_q) * AW'(MAX_JOINTS) + AW'(jsel);
	assign dt       = {1'b0, t_q} - {1'b0, trd[63:32]};
	assign ua       = a0_q[31] ? (~a0_q + 32'd1) : a0_q;
	assign uv       = v0_q[31] ? (~v0_q + 32'd1) : v0_q;
	assign qtmp     = {31'b0, hi_q[0], 32'b0} + lo_q;
	assign q_last   = ((j_q + NW'(1)) == n);

	always_comb begin
		lin_v = $signed({18'b0, lv_q});
		if (dneg_q ^ v0_q[31]) begin
			lin_v = -lin_v;
		end
		lin_a = $signed({18'b0, la_q});
		if (dneg_q ^ a0_q[31]) begin
			lin_a = -lin_a;
		end
		quad = $signed({3'b0, qd_q});
		if (a0_q[31]) begin
			quad = -quad;
		end
		p_sat = sat32($signed({{34{q0_q[31]}}, q0_q}) + lin_v + quad);
		v_sat = sat32($signed({{34{v0_q[31]}}, v0_q}) + lin_a);
	end

	always_comb begin
		t_raddr = '0;
		case (state_q)
			S_DEC: begin
				if (is_query) begin
					t_raddr = c_calc;
				end else begin
					t_raddr = SW'(count_q - CW'(1));
				end
			end
			S_LK_TB: t_raddr = c_calc;
			S_LK_C: begin
				if (!hit && ((CW'(cache_q) + CW'(1)) < count_q)) begin
					t_raddr = cache_q + SW'(1);
				end
			end
			S_LK_S:  t_raddr = i_q + SW'(1);
			S_EA:    t_raddr = s_q;
			default: t_raddr = '0;
		endcase
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			S_M1: begin
				ma = ud_q;
				mb = ud_q;
			end
			S_M2: begin
				ma = prod_q[63:32];
				mb = ua;
			end
			S_M3: begin
				ma = d2lo_q;
				mb = ua;
			end
			S_M4: begin
				ma = ud_q;
				mb = uv;
			end
			S_M5: begin
				ma = ud_q;
				mb = ua;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(ma) * 64'(mb);
		if (pop) begin
			cur_q <= head;
		end
		case (state_q)
			S_EDT: begin
				q0_q   <= jrd[95:64];
				v0_q   <= jrd[63:32];
				a0_q   <= jrd[31:0];
				dneg_q <= dt[32];
				ud_q   <= dt[32] ? (~dt[31:0] + 32'd1) : dt[31:0];
			end
			S_M2:    d2lo_q <= prod_q[31:0];
			S_M3:    hi_q <= prod_q;
			S_M4:    lo_q <= prod_q;
			S_M5:    lv_q <= prod_q[63:16];
			S_M6: begin
				la_q <= prod_q[63:16];
				qd_q <= hi_q[63:1] + 63'(qtmp[63:33]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			cache_q  <= '0;
			i_q      <= '0;
			s_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
			tw_q     <= 1'b0;
			twa_q    <= '0;
			twd_q    <= '0;
			jw_q     <= 1'b0;
			jwa_q    <= '0;
			jwd_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			tw_q     <= 1'b0;
			jw_q     <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (head_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q  <= S_IDLE;
					res_q    <= '0;
					res_q.out_joint <= cur_q.joint;
					res_q.last      <= 1'b1;
					res_q.status    <= ST_OK;
					strobe_q <= 1'b1;
					case (cur_q.op)
						OP_CLEAR: begin
							count_q <= '0;
							cache_q <= '0;
						end
						OP_START: begin
							if (count_q != '0) begin
								res_q.status <= ST_NOTEMPTY;
							end else if (cur_q.time_req <= cur_q.start_time) begin
								res_q.status <= ST_ORDER;
							end else begin
								tw_q  <= 1'b1;
								twa_q <= '0;
								twd_q <= {cur_q.start_time, cur_q.time_req};
								jw_q  <= jok;
								jwa_q <= AW'(cur_q.joint);
								jwd_q <= {cur_q.pos_value, cur_q.vel_value, cur_q.acc_value};
								if (cur_q.last_joint) begin
									count_q <= CW'(1);
								end
							end
						end
						OP_QUERY: begin
							if (count_q == '0) begin
								res_q.out_joint <= '0;
								res_q.status    <= ST_EMPTY;
							end else begin
								strobe_q <= 1'b0;
								t_q      <= cur_q.time_req;
								cache_q  <= c_calc;
								j_q      <= '0;
								state_q  <= S_LK_C;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_q.status <= ST_EMPTY;
							end else if (count_q >= CW'(MAX_SEGMENTS)) begin
								res_q.status <= ST_FULL;
							end else begin
								strobe_q <= 1'b0;
								state_q  <= S_LK_TB;
							end
						end
					endcase
				end
				S_LK_TB: begin
					if (cur_q.time_req <= trd[31:0]) begin
						res_q    <= '0;
						res_q.out_joint <= cur_q.joint;
						res_q.last      <= 1'b1;
						res_q.status    <= ST_ORDER;
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						t_q     <= trd[31:0];
						cache_q <= c_calc;
						state_q <= S_LK_C;
					end
				end
				S_LK_C: begin
					i_q <= '0;
					if (hit) begin
						s_q     <= cache_q;
						state_q <= S_EA;
					end else if ((CW'(cache_q) + CW'(1)) < count_q) begin
						state_q <= S_LK_N;
					end else if (t_gt_e) begin
						s_q     <= cache_q;
						state_q <= S_EA;
					end else begin
						state_q <= S_LK_S;
					end
				end
				S_LK_N: begin
					if (hit) begin
						cache_q <= cache_q + SW'(1);
						s_q     <= cache_q + SW'(1);
						state_q <= S_EA;
					end else begin
						state_q <= S_LK_S;
					end
				end
				S_LK_S: begin
					if (((CW'(i_q) + CW'(1)) < count_q) && t_gt_e) begin
						i_q <= i_q + SW'(1);
					end else begin
						s_q     <= i_q;
						state_q <= S_EA;
					end
				end
				S_EA: begin
					if (!is_query && !jok) begin
						tw_q  <= 1'b1;
						twa_q <= SW'(count_q);
						twd_q <= {t_q, cur_q.time_req};
						if (cur_q.last_joint) begin
							count_q <= count_q + CW'(1);
						end
						res_q    <= '0;
						res_q.out_joint <= cur_q.joint;
						res_q.last      <= 1'b1;
						res_q.status    <= ST_OK;
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						state_q <= S_EDT;
					end
				end
				S_EDT:   state_q <= S_M1;
				S_M1:    state_q <= S_M2;
				S_M2:    state_q <= S_M3;
				S_M3:    state_q <= S_M4;
				S_M4:    state_q <= S_M5;
				S_M5:    state_q <= S_M6;
				S_M6:    state_q <= S_SUM;
				S_SUM: begin
					strobe_q <= 1'b1;
					res_q.status <= ST_OK;
					if (is_query) begin
						res_q.out_joint    <= 3'(j_q);
						res_q.position     <= p_sat;
						res_q.velocity     <= v_sat;
						res_q.acceleration <= a0_q;
						res_q.last         <= q_last;
						if (q_last) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + NW'(1);
							state_q <= S_EA;
						end
					end else begin
						tw_q  <= 1'b1;
						twa_q <= SW'(count_q);
						twd_q <= {t_q, cur_q.time_req};
						jw_q  <= 1'b1;
						jwa_q <= AW'(count_q) * AW'(MAX_JOINTS) + AW'(cur_q.joint);
						if (cur_q.op == OP_LINK_VEL) begin
							jwd_q <= {p_sat, cur_q.vel_value, 32'sd0};
						end else begin
							jwd_q <= {p_sat, v_sat, cur_q.acc_value};
						end
						if (cur_q.last_joint) begin
							count_q <= count_q + CW'(1);
						end
						res_q <= '0;
						res_q.out_joint <= cur_q.joint;
						res_q.last      <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`PTTE_AST_IMP(a_count_range, 1'b1, count_q <= CW'(MAX_SEGMENTS), "segment count overflow")
	`PTTE_AST_IMP(a_strobe_src, strobe_q, $past(state_q) == S_DEC || $past(state_q) == S_LK_TB || $past(state_q) == S_EA || $past(state_q) == S_SUM, "word from wrong state")
	`PTTE_AST_IMP(a_mid_query, strobe_q && !res_q.last, state_q == S_EA, "query run broken")
endmodule

@@ hdl/piecewise_trajectory_table_evaluator.sv @@
// Channel  | Ports                     | Handshake
// ---------+---------------------------+----------------------------------
// command  | start, item, busy         | taken when start && !busy
// result   | strobe, result            | one cycle per word, no backpressure
// config   | cfg_we, cfg_wdata         | joints_used written when cfg_we
//
// A two-word command queue accepts while the evaluator works; busy rises only
// when both entries hold words. Clear, start and writes rejected on an empty or
// full table answer from the decode state; links rejected on end time answer
// from the time-base lookup. Lookup tries the cached segment, then the next one,
// then a linear scan. Each joint evaluation uses the one shared 32x32 multiplier
// (five products in turn, then quad term and saturating sums).
// Reset clears segment count, cache and joints_used (to 6); tables are not cleared.
module piecewise_trajectory_table_evaluator #(
	parameter int MAX_SEGMENTS = 16,
	parameter int MAX_JOINTS   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ptte_pkg::item_t   item,
	output logic              busy,
	output logic              strobe,
	output ptte_pkg::result_t result,
	input  logic              cfg_we,
	input  logic [3:0]        cfg_wdata
);
	import ptte_pkg::*;

	localparam int NW = $clog2(MAX_JOINTS + 1);

	logic [3:0]    joints_used_q;
	logic [NW-1:0] n;
	item_t         head;
	logic          head_valid;
	logic          pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joints_used_q <= JOINTS_RESET;
		end else if (cfg_we) begin
			joints_used_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (joints_used_q == 4'd0) begin
			n = NW'(1);
		end else if (32'(joints_used_q) > MAX_JOINTS) begin
			n = NW'(MAX_JOINTS);
		end else begin
			n = NW'(joints_used_q);
		end
	end

	ptte_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	ptte_back #(
		.MAX_SEGMENTS (MAX_SEGMENTS),
		.MAX_JOINTS   (MAX_JOINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.n          (n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.result     (result),
		.strobe     (strobe)
	);
endmodule
